>>> hdl/tun_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and constants of the triangle unit normal pipeline.
package tun_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 14;

  // edge differences are cut back to 31 bits for wide coordinates
  localparam int DIFF_SHIFT = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int DIFF_W     = COORD_WIDTH + 1 - DIFF_SHIFT;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int SH_W       = $clog2(CROSS_W + 1);
  localparam int RED_W      = 31;
  localparam int SQ_W       = 2 * RED_W;
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int Q_W        = NORMAL_FRAC_BITS + 1;
  localparam int NUM_W      = RED_W + NORMAL_FRAC_BITS + 2;
  localparam int OUT_W      = 16;
  localparam int OUT_MAX    = 32767;

  typedef struct packed {
    logic       enough;
    logic       degen;
    logic [2:0] neg;
  } meta_t;

  typedef logic [RED_W-1:0] red_t;

  // difference of two coordinates, magnitude shifted toward zero
  function automatic logic signed [DIFF_W-1:0] diff_tz(
    logic signed [COORD_WIDTH-1:0] b,
    logic signed [COORD_WIDTH-1:0] a
  );
    logic signed [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0]        m;
    logic [COORD_WIDTH:0]        r;
    d = $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
    m = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);
    m = m >> DIFF_SHIFT;
    r = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-m) : m;
    return DIFF_W'(r);
  endfunction

endpackage

>>> hdl/triangle_unit_normal.sv
`timescale 1ns / 1ps
// Pipeline: edge vectors and cross product, norm, 32 root stages and the
// one-bit-per-stage divider, with Q1.14 output.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits and advances when it is taken or the output stage is empty.
// Reset clears all valid bits; data registers are not reset.
module triangle_unit_normal (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] ax_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] ay_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] az_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] bx_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] by_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] bz_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cx_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cy_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cz_i,
  input  logic                                   enough_vertices_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [tun_pkg::OUT_W-1:0]       normal_x_o,
  output logic signed [tun_pkg::OUT_W-1:0]       normal_y_o,
  output logic signed [tun_pkg::OUT_W-1:0]       normal_z_o,
  output logic                                   computed_o,
  output logic                                   degenerate_o
);

  logic en;
  logic cr_valid;
  logic cr_enough;
  logic signed [tun_pkg::CROSS_W-1:0] nx;
  logic signed [tun_pkg::CROSS_W-1:0] ny;
  logic signed [tun_pkg::CROSS_W-1:0] nz;
  logic                               nm_valid;
  tun_pkg::meta_t                     nm_meta;
  tun_pkg::red_t                      nm_r [3];
  logic [tun_pkg::SUM_W-1:0]          nm_s;
  logic                               sq_valid;
  tun_pkg::meta_t                     sq_meta;
  tun_pkg::red_t                      sq_r [3];
  logic [tun_pkg::ROOT_W-1:0]         sq_root;
  logic signed [tun_pkg::OUT_W-1:0]   normal [3];

  // advance everything unless a finished word is stuck at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  tun_cross u_cross (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .ax_i     (ax_i),
    .ay_i     (ay_i),
    .az_i     (az_i),
    .bx_i     (bx_i),
    .by_i     (by_i),
    .bz_i     (bz_i),
    .cx_i     (cx_i),
    .cy_i     (cy_i),
    .cz_i     (cz_i),
    .enough_i (enough_vertices_i),
    .valid_o  (cr_valid),
    .enough_o (cr_enough),
    .nx_o     (nx),
    .ny_o     (ny),
    .nz_o     (nz)
  );

  tun_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cr_valid),
    .enough_i (cr_enough),
    .nx_i     (nx),
    .ny_i     (ny),
    .nz_i     (nz),
    .valid_o  (nm_valid),
    .meta_o   (nm_meta),
    .r_o      (nm_r),
    .s_o      (nm_s)
  );

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid),
    .meta_i  (nm_meta),
    .r_i     (nm_r),
    .s_i     (nm_s),
    .valid_o (sq_valid),
    .meta_o  (sq_meta),
    .r_o     (sq_r),
    .root_o  (sq_root)
  );

  tun_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (sq_valid),
    .meta_i       (sq_meta),
    .r_i          (sq_r),
    .root_i       (sq_root),
    .valid_o      (out_valid_o),
    .normal_o     (normal),
    .computed_o   (computed_o),
    .degenerate_o (degenerate_o)
  );

  assign normal_x_o = normal[0];
  assign normal_y_o = normal[1];
  assign normal_z_o = normal[2];

  a_degen_needs_computed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> computed_o)
    else $error("degenerate flagged without a computed normal");

  a_skip_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !computed_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("nonzero normal for a polygon with too few vertices");

  a_unit_not_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && computed_o && !degenerate_o |->
      normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
    else $error("zero normal from a nonzero cross product");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o) && $stable(computed_o))
    else $error("output word changed while stalled");

endmodule

>>> hdl/tun_cross.sv
`timescale 1ns / 1ps
// Edge vectors and cross product, three register stages.
module tun_cross (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] ax_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] ay_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] az_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] bx_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] by_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] bz_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cx_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cy_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cz_i,
  input  logic                                   enough_i,
  output logic                                   valid_o,
  output logic                                   enough_o,
  output logic signed [tun_pkg::CROSS_W-1:0]     nx_o,
  output logic signed [tun_pkg::CROSS_W-1:0]     ny_o,
  output logic signed [tun_pkg::CROSS_W-1:0]     nz_o
);

  logic [2:0] valid_q;
  logic [2:0] enough_q;
  logic signed [tun_pkg::DIFF_W-1:0] u_q [3];
  logic signed [tun_pkg::DIFF_W-1:0] v_q [3];
  logic signed [tun_pkg::PROD_W-1:0] p_q [6];
  logic signed [tun_pkg::CROSS_W-1:0] n_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      enough_q <= {enough_q[1:0], enough_i};
      u_q[0] <= tun_pkg::diff_tz(bx_i, ax_i);
      u_q[1] <= tun_pkg::diff_tz(by_i, ay_i);
      u_q[2] <= tun_pkg::diff_tz(bz_i, az_i);
      v_q[0] <= tun_pkg::diff_tz(cx_i, ax_i);
      v_q[1] <= tun_pkg::diff_tz(cy_i, ay_i);
      v_q[2] <= tun_pkg::diff_tz(cz_i, az_i);
      p_q[0] <= u_q[1] * v_q[2];
      p_q[1] <= u_q[2] * v_q[1];
      p_q[2] <= u_q[2] * v_q[0];
      p_q[3] <= u_q[0] * v_q[2];
      p_q[4] <= u_q[0] * v_q[1];
      p_q[5] <= u_q[1] * v_q[0];
      n_q[0] <= tun_pkg::CROSS_W'(p_q[0]) - tun_pkg::CROSS_W'(p_q[1]);
      n_q[1] <= tun_pkg::CROSS_W'(p_q[2]) - tun_pkg::CROSS_W'(p_q[3]);
      n_q[2] <= tun_pkg::CROSS_W'(p_q[4]) - tun_pkg::CROSS_W'(p_q[5]);
    end
  end

  assign valid_o  = valid_q[2];
  assign enough_o = enough_q[2];
  assign nx_o     = n_q[0];
  assign ny_o     = n_q[1];
  assign nz_o     = n_q[2];

endmodule

>>> hdl/tun_norm.sv
`timescale 1ns / 1ps
// Magnitudes, range reduction to 31 bits and sum of squares, five stages.
module tun_norm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               enough_i,
  input  logic signed [tun_pkg::CROSS_W-1:0] nx_i,
  input  logic signed [tun_pkg::CROSS_W-1:0] ny_i,
  input  logic signed [tun_pkg::CROSS_W-1:0] nz_i,
  output logic                               valid_o,
  output tun_pkg::meta_t                     meta_o,
  output tun_pkg::red_t                      r_o [3],
  output logic [tun_pkg::SUM_W-1:0]          s_o
);

  logic [4:0]                      valid_q;
  tun_pkg::meta_t                  meta_q [5];
  logic [tun_pkg::CROSS_W-1:0]     mag4_q [3];
  logic [tun_pkg::CROSS_W-1:0]     mag5_q [3];
  logic [tun_pkg::SH_W-1:0]        sh_q;
  tun_pkg::red_t                   r6_q [3];
  tun_pkg::red_t                   r7_q [3];
  tun_pkg::red_t                   r8_q [3];
  logic [tun_pkg::SQ_W-1:0]        sq_q [3];
  logic [tun_pkg::SUM_W-1:0]       s_q;

  logic [tun_pkg::CROSS_W-1:0] or_mag;
  logic [tun_pkg::SH_W-1:0]    blen;
  logic [tun_pkg::SH_W-1:0]    sh_d;
  tun_pkg::meta_t              meta4_d;
  tun_pkg::meta_t              meta5_d;
  logic [tun_pkg::CROSS_W-1:0] mag_d [3];

  always_comb begin
    meta4_d        = '0;
    meta4_d.enough = enough_i;
    meta4_d.neg    = {nz_i[tun_pkg::CROSS_W-1], ny_i[tun_pkg::CROSS_W-1],
                      nx_i[tun_pkg::CROSS_W-1]};
    mag_d[0] = nx_i[tun_pkg::CROSS_W-1] ? tun_pkg::CROSS_W'(-nx_i) : tun_pkg::CROSS_W'(nx_i);
    mag_d[1] = ny_i[tun_pkg::CROSS_W-1] ? tun_pkg::CROSS_W'(-ny_i) : tun_pkg::CROSS_W'(ny_i);
    mag_d[2] = nz_i[tun_pkg::CROSS_W-1] ? tun_pkg::CROSS_W'(-nz_i) : tun_pkg::CROSS_W'(nz_i);
  end

  // bit length of the largest magnitude equals that of the OR of all three
  always_comb begin
    or_mag = mag4_q[0] | mag4_q[1] | mag4_q[2];
    blen   = '0;
    for (int i = 0; i < tun_pkg::CROSS_W; i++) begin
      if (or_mag[i]) begin
        blen = tun_pkg::SH_W'(i + 1);
      end
    end
    sh_d = (32'(blen) > tun_pkg::RED_W) ? tun_pkg::SH_W'(32'(blen) - tun_pkg::RED_W) : '0;
    meta5_d       = meta_q[0];
    meta5_d.degen = (or_mag == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0]       <= meta4_d;
      meta_q[1]       <= meta5_d;
      meta_q[2]       <= meta_q[1];
      meta_q[3]       <= meta_q[2];
      meta_q[4]       <= meta_q[3];
      sh_q            <= sh_d;
      for (int c = 0; c < 3; c++) begin
        mag4_q[c] <= mag_d[c];
        mag5_q[c] <= mag4_q[c];
        r6_q[c]   <= tun_pkg::RED_W'(mag5_q[c] >> sh_q);
        r7_q[c]   <= r6_q[c];
        sq_q[c]   <= r6_q[c] * r6_q[c];
        r8_q[c]   <= r7_q[c];
      end
      s_q <= tun_pkg::SUM_W'(sq_q[0]) + tun_pkg::SUM_W'(sq_q[1]) + tun_pkg::SUM_W'(sq_q[2]);
    end
  end

  assign valid_o = valid_q[4];
  assign meta_o  = meta_q[4];
  assign r_o     = r8_q;
  assign s_o     = s_q;

endmodule

>>> hdl/tun_sqrt.sv
`timescale 1ns / 1ps
// Integer square root, one result bit per register stage.
module tun_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  tun_pkg::meta_t               meta_i,
  input  tun_pkg::red_t                r_i [3],
  input  logic [tun_pkg::SUM_W-1:0]    s_i,
  output logic                         valid_o,
  output tun_pkg::meta_t               meta_o,
  output tun_pkg::red_t                r_o [3],
  output logic [tun_pkg::ROOT_W-1:0]   root_o
);

  localparam int N = tun_pkg::ROOT_W;

  logic [N:0]                    v_s;
  tun_pkg::meta_t                meta_s [N+1];
  tun_pkg::red_t                 r_s    [N+1][3];
  logic [tun_pkg::SUM_W-1:0]     x_s    [N+1];
  logic [tun_pkg::SUM_W-1:0]     res_s  [N+1];

  assign v_s[0]    = valid_i;
  assign meta_s[0] = meta_i;
  assign r_s[0]    = r_i;
  assign x_s[0]    = s_i;
  assign res_s[0]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [tun_pkg::SUM_W-1:0] Bit = tun_pkg::SUM_W'(1) << (2 * (N - 1 - k));
    logic [tun_pkg::SUM_W-1:0] trial;
    logic [tun_pkg::SUM_W-1:0] x_d;
    logic [tun_pkg::SUM_W-1:0] res_d;

    always_comb begin
      trial = res_s[k] + Bit;
      if (x_s[k] >= trial) begin
        x_d   = x_s[k] - trial;
        res_d = (res_s[k] >> 1) + Bit;
      end else begin
        x_d   = x_s[k];
        res_d = res_s[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_s[k+1] <= meta_s[k];
        r_s[k+1]    <= r_s[k];
        x_s[k+1]    <= x_d;
        res_s[k+1]  <= res_d;
      end
    end
  end

  assign valid_o = v_s[N];
  assign meta_o  = meta_s[N];
  assign r_o     = r_s[N];
  assign root_o  = res_s[N][tun_pkg::ROOT_W-1:0];

endmodule

>>> hdl/tun_div.sv
`timescale 1ns / 1ps
// Rounded division of each component by the length, restoring, one quotient bit per stage.
module tun_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  tun_pkg::meta_t                    meta_i,
  input  tun_pkg::red_t                     r_i [3],
  input  logic [tun_pkg::ROOT_W-1:0]        root_i,
  output logic                              valid_o,
  output logic signed [tun_pkg::OUT_W-1:0]  normal_o [3],
  output logic                              computed_o,
  output logic                              degenerate_o
);

  localparam int N = tun_pkg::Q_W;

  logic [N:0]                    v_s;
  tun_pkg::meta_t                meta_s [N+1];
  logic [tun_pkg::ROOT_W:0]      d_s    [N+1];
  logic [tun_pkg::NUM_W-1:0]     rem_s  [N+1][3];
  logic [N-1:0]                  q_s    [N+1][3];

  logic                             valid_q;
  logic signed [tun_pkg::OUT_W-1:0] normal_q [3];
  logic                             computed_q;
  logic                             degenerate_q;

  // setup stage: numerator 2*R*2^F + L, divisor 2*L
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_s[0] <= meta_i;
      d_s[0]    <= {root_i, 1'b0};
      for (int c = 0; c < 3; c++) begin
        rem_s[0][c] <= (tun_pkg::NUM_W'(r_i[c]) << (tun_pkg::NORMAL_FRAC_BITS + 1))
                       + tun_pkg::NUM_W'(root_i);
        q_s[0][c]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int Bp = N - 1 - k;
    logic [tun_pkg::NUM_W-1:0] dsh;
    logic [tun_pkg::NUM_W-1:0] rem_d [3];
    logic [N-1:0]              q_d   [3];

    always_comb begin
      dsh = tun_pkg::NUM_W'(d_s[k]) << Bp;
      for (int c = 0; c < 3; c++) begin
        rem_d[c] = rem_s[k][c];
        q_d[c]   = q_s[k][c];
        if (rem_s[k][c] >= dsh) begin
          rem_d[c]   = rem_s[k][c] - dsh;
          q_d[c][Bp] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_s[k+1] <= meta_s[k];
        d_s[k+1]    <= d_s[k];
        rem_s[k+1]  <= rem_d;
        q_s[k+1]    <= q_d;
      end
    end
  end

  // saturate, restore sign, zero on too few vertices or zero length
  logic signed [tun_pkg::OUT_W-1:0] normal_d [3];
  logic [tun_pkg::OUT_W-1:0]        sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat[c] = (32'(q_s[N][c]) > 32'(tun_pkg::OUT_MAX)) ? tun_pkg::OUT_W'(tun_pkg::OUT_MAX)
                                                        : tun_pkg::OUT_W'(q_s[N][c]);
      if (!meta_s[N].enough || meta_s[N].degen) begin
        normal_d[c] = '0;
      end else if (meta_s[N].neg[c]) begin
        normal_d[c] = tun_pkg::OUT_W'(-sat[c]);
      end else begin
        normal_d[c] = sat[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= v_s[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      normal_q     <= normal_d;
      computed_q   <= meta_s[N].enough;
      degenerate_q <= meta_s[N].enough & meta_s[N].degen;
    end
  end

  assign valid_o      = valid_q;
  assign normal_o     = normal_q;
  assign computed_o   = computed_q;
  assign degenerate_o = degenerate_q;

endmodule

>>> tb/triangle_unit_normal_checker.sv
`timescale 1ns / 1ps
// Checker for the triangle unit normal block: predicts each result word and compares.
module triangle_unit_normal_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] ax_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] ay_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] az_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] bx_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] by_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] bz_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cx_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cy_i,
  input  logic signed [tun_pkg::COORD_WIDTH-1:0] cz_i,
  input  logic                                   enough_vertices_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic signed [tun_pkg::OUT_W-1:0]       normal_x_i,
  input  logic signed [tun_pkg::OUT_W-1:0]       normal_y_i,
  input  logic signed [tun_pkg::OUT_W-1:0]       normal_z_i,
  input  logic                                   computed_i,
  input  logic                                   degenerate_i,
  output int                                     errors_o,
  output int                                     pending_o
);
  import tun_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nz;
    logic             computed;
    logic             degenerate;
  } normal_word_t;

  normal_word_t normal_q[$];

  assign pending_o = normal_q.size();

  function automatic logic signed [63:0] edge_diff(logic signed [COORD_WIDTH-1:0] b,
                                                   logic signed [COORD_WIDTH-1:0] a);
    logic signed [63:0] d;
    logic [63:0]        m;
    d = 64'(b) - 64'(a);
    m = (d < 0) ? -d : d;
    m = m >> DIFF_SHIFT;
    return (d < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic normal_word_t unit_normal(
    logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    logic enough);
    normal_word_t       w;
    logic signed [63:0] u[3], v[3], n[3];
    logic [63:0]        mg[3], m, s, len, q;
    int                 bl, sh;
    w = '0;
    if (!enough) return w;
    w.computed = 1'b1;
    u[0] = edge_diff(bx, ax); u[1] = edge_diff(by, ay); u[2] = edge_diff(bz, az);
    v[0] = edge_diff(cx, ax); v[1] = edge_diff(cy, ay); v[2] = edge_diff(cz, az);
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (n[i] < 0) ? -n[i] : n[i];
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) begin
      w.degenerate = 1'b1;
      return w;
    end
    bl = 0;
    for (int i = 0; i < 64; i++) if (m[i]) bl = i + 1;
    sh = (bl > 31) ? bl - 31 : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mg[i] >> sh;
      s += mg[i] * mg[i];
    end
    len = root64(s);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << NORMAL_FRAC_BITS) * 2 + len) / (2 * len);
      if (q > OUT_MAX) q = OUT_MAX;
      if (n[i] < 0) q = -q;
      if (i == 0) w.nx = q[OUT_W-1:0];
      else if (i == 1) w.ny = q[OUT_W-1:0];
      else w.nz = q[OUT_W-1:0];
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i) begin
    normal_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        normal_q.push_back(unit_normal(ax_i, ay_i, az_i, bx_i, by_i, bz_i,
                                       cx_i, cy_i, cz_i, enough_vertices_i));
      if (out_valid_i && out_ready_i) begin
        if (normal_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          w = normal_q.pop_front();
          if (normal_x_i !== w.nx) report_mismatch("normal_x", normal_x_i, w.nx);
          if (normal_y_i !== w.ny) report_mismatch("normal_y", normal_y_i, w.ny);
          if (normal_z_i !== w.nz) report_mismatch("normal_z", normal_z_i, w.nz);
          if (computed_i !== w.computed) report_mismatch("computed", computed_i, w.computed);
          if (degenerate_i !== w.degenerate)
            report_mismatch("degenerate", degenerate_i, w.degenerate);
        end
      end
    end
  end

endmodule

>>> tb/triangle_unit_normal_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives triangles into the unit normal block and gives the verdict.
module triangle_unit_normal_tb;
  import tun_pkg::*;

  localparam int RANDOM_WORDS = 1750;
  localparam int STALL_LIMIT  = 5000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [COORD_WIDTH-1:0] ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i;
  logic enough_vertices_i;
  logic signed [OUT_W-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic computed_o, degenerate_o;
  int   errors, pending, idle_cycles;
  bit   hold_off_rx;

  triangle_unit_normal dut (.*);

  triangle_unit_normal_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .enough_vertices_i, .out_valid_i(out_valid_o), .out_ready_i,
    .normal_x_i(normal_x_o), .normal_y_i(normal_y_o), .normal_z_i(normal_z_o),
    .computed_i(computed_o), .degenerate_i(degenerate_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one triangle word; hold it until taken.
  task automatic send_triangle(logic [COORD_WIDTH-1:0] c[9], logic en);
    in_valid_i <= 1'b1;
    {ax_i, ay_i, az_i} <= {c[0], c[1], c[2]};
    {bx_i, by_i, bz_i} <= {c[3], c[4], c[5]};
    {cx_i, cy_i, cz_i} <= {c[6], c[7], c[8]};
    enough_vertices_i <= en;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_WIDTH'($urandom_range(0, 15));
      1: return COORD_WIDTH'(-$urandom_range(0, 15));
      2: return {1'b0, {(COORD_WIDTH-1){1'b1}}} - COORD_WIDTH'($urandom_range(0, 3));
      3: return {1'b1, {(COORD_WIDTH-1){1'b0}}} + COORD_WIDTH'($urandom_range(0, 3));
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  task automatic random_triangle();
    logic [COORD_WIDTH-1:0] c[9];
    int kind;
    kind = $urandom_range(0, 19);
    foreach (c[i]) c[i] = rand_coord();
    if (kind == 0) begin
      // collinear: C = A + 2(B - A)
      for (int i = 0; i < 3; i++) c[6+i] = c[i] + ((c[3+i] - c[i]) << 1);
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) c[3+i] = c[i];
    end
    send_triangle(c, kind != 2);
  endtask

  task automatic directed_triangles();
    logic [COORD_WIDTH-1:0] c[9];
    logic [COORD_WIDTH-1:0] mx, mn;
    mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};  send_triangle(c, 1'b1);
    c = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};  send_triangle(c, 1'b1);
    c = '{0, 0, 0, 0, 0, 1, 1, 0, 0};        send_triangle(c, 1'b1);
    send_triangle(c, 1'b0);
    c = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; send_triangle(c, 1'b1);
    c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};        send_triangle(c, 1'b1);
    c = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; send_triangle(c, 1'b1);
    c = '{mx, mx, mx, mn, mx, mx, mx, mn, mx}; send_triangle(c, 1'b1);
    c = '{mn, mx, mn, mx, mn, mx, mn, mn, mx}; send_triangle(c, 1'b1);
    c = '{mx, mn, mx, mn, mx, mn, mx, mx, mn}; send_triangle(c, 1'b0);
    c = '{0, 0, 0, 1, 1, 0, 1, 2, 0};        send_triangle(c, 1'b1);
    c = '{0, 0, 0, 3, 1, 7, 5, 2, 9};        send_triangle(c, 1'b1);
    c = '{-1, -1, -1, -1, -1, -1, 5, 6, 7};  send_triangle(c, 1'b1);
  endtask

  // Receiver: random stalls and one long hold-off.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_rx) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 199) < 3) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off_rx = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off_rx = 1'b0;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    hold_off_rx = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i} = '0;
    enough_vertices_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    directed_triangles();
    in_valid_i <= 1'b0;
    // drain fully before the random part
    while (pending != 0) @(negedge clk_i);
    for (int n = 0; n < RANDOM_WORDS; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) random_triangle();
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (errors == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
